### rtl/chorus_modulated_delay_top_defines.svh
// ---------------------------------------------------------------------------
// chorus_modulated_delay_top_defines.svh
// Assertion macros for the chorus delay block.
// ---------------------------------------------------------------------------
`ifndef CHORUS_MODULATED_DELAY_TOP_DEFINES_SVH
`define CHORUS_MODULATED_DELAY_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CHMD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every edge including reset.
`define CHMD_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/chmd_pkg.sv
// ---------------------------------------------------------------------------
// chmd_pkg
// Shared types and constants of the chorus delay block.
// ---------------------------------------------------------------------------
package chmd_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int PHASE_W    = 32;
  localparam int SWING_W    = 18;
  localparam int SINE_W     = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  localparam cfg_idx_t CFG_PHASE_STEP = 2'd0;
  localparam cfg_idx_t CFG_SWING      = 2'd1;

  // Base delay of 300 samples, Q8.
  localparam int BASE_DELAY_Q8 = 300 * 256;

  // Sine table generation, Q30.
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint TAYLOR_DIV [7] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
                                        64'sd110, 64'sd156, 64'sd210};

endpackage

### rtl/chmd_fifo.sv
// ---------------------------------------------------------------------------
// chmd_fifo
// Small register queue; head entry shown while not empty.
// ---------------------------------------------------------------------------
module chmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/chmd_front.sv
// ---------------------------------------------------------------------------
// chmd_front
// Accepts samples, snapshots and advances the channel's oscillator phase,
// write position and fill flag, and queues the work for the back end.
// ---------------------------------------------------------------------------
module chmd_front #(
  parameter int DELAY_LENGTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  chmd_pkg::sample_t             sample_in,
  input  logic                          channel,
  input  logic [chmd_pkg::PHASE_W-1:0]  phase_step,
  input  logic                          cmd_full,
  output logic                          cmd_push,
  output logic [chmd_pkg::SAMPLE_W+chmd_pkg::PHASE_W+$clog2(DELAY_LENGTH)+1:0] cmd_data
);
  import chmd_pkg::*;

  localparam int AW = $clog2(DELAY_LENGTH);

  logic [PHASE_W-1:0] phase_r [2];
  logic [AW-1:0]      wi_r    [2];
  logic               wrap_r  [2];
  logic [AW-1:0]      wi_cur;
  logic               wi_last;

  assign cmd_push = push && !cmd_full;
  assign wi_cur   = wi_r[channel];
  assign wi_last  = (wi_cur == AW'(DELAY_LENGTH - 1));
  assign cmd_data = {sample_in, channel, phase_r[channel], wi_cur, wrap_r[channel]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 2; c++) begin
        phase_r[c] <= '0;
        wi_r[c]    <= '0;
        wrap_r[c]  <= 1'b0;
      end
    end else if (cmd_push) begin
      phase_r[channel] <= phase_r[channel] + phase_step;
      wi_r[channel]    <= wi_last ? '0 : wi_cur + 1'b1;
      if (wi_last) begin
        wrap_r[channel] <= 1'b1;
      end
    end
  end

endmodule

### rtl/chmd_back.sv
// ---------------------------------------------------------------------------
// chmd_back
// Sequencer: stores the sample, looks up the sine, forms the modulated read
// position, reads two neighbors from the delay store and mixes.
// ---------------------------------------------------------------------------
module chmd_back #(
  parameter int DELAY_LENGTH     = 2048,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [chmd_pkg::SWING_W-1:0]  swing,
  input  logic                          cmd_empty,
  input  logic [chmd_pkg::SAMPLE_W+chmd_pkg::PHASE_W+$clog2(DELAY_LENGTH)+1:0] cmd_data,
  output logic                          cmd_pop,
  input  logic                          res_full,
  output logic                          res_push,
  output chmd_pkg::sample_t             res_data
);
  import chmd_pkg::*;

  localparam int AW    = $clog2(DELAY_LENGTH);
  localparam int TIX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int PW    = AW + 11;
  localparam logic signed [PW-1:0] MOD_Q8 = PW'(DELAY_LENGTH * 256);
  localparam logic [TIX_W:0] DEPTH_C = (TIX_W+1)'(SINE_TABLE_DEPTH);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_IDX   = 4'd1;
  localparam logic [3:0] ST_ROM   = 4'd2;
  localparam logic [3:0] ST_SWING = 4'd3;
  localparam logic [3:0] ST_POS   = 4'd4;
  localparam logic [3:0] ST_WRAP  = 4'd5;
  localparam logic [3:0] ST_WRAP2 = 4'd6;
  localparam logic [3:0] ST_RD1   = 4'd7;
  localparam logic [3:0] ST_RD2   = 4'd8;
  localparam logic [3:0] ST_ACC   = 4'd9;
  localparam logic [3:0] ST_MIX   = 4'd10;

  function automatic logic signed [SINE_W-1:0] sine_entry(input int k);
    longint k4, quad, rem, x, v, term, sum;
    int     n;
    k4   = 4 * longint'(k);
    quad = k4 / SINE_TABLE_DEPTH;
    rem  = k4 % SINE_TABLE_DEPTH;
    if (quad == 1 || quad == 3) begin
      rem = SINE_TABLE_DEPTH - rem;
    end
    x    = rem * HALF_PI_Q30 / SINE_TABLE_DEPTH;
    term = x;
    sum  = x;
    for (n = 0; n < 7; n++) begin
      term = term * x / ONE_Q30;
      term = term * x / ONE_Q30;
      term = -term / TAYLOR_DIV[n];
      sum  = sum + term;
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum + 64'sd16384) >>> 15;
    if (v > 32767) begin
      v = 32767;
    end
    if (quad >= 2) begin
      v = -v;
    end
    return SINE_W'(v);
  endfunction

  logic signed [SINE_W-1:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k);
  end

  logic [SAMPLE_W-1:0] store_mem [2**(AW+1)];

  logic [3:0]               state_r, state_nxt;
  sample_t                  dry_r;
  logic                     ch_r;
  logic [PHASE_W-1:0]       phase_r;
  logic [AW-1:0]            wi_r;
  logic                     wrap_r;
  logic [TIX_W-1:0]         tix_r;
  logic signed [SINE_W-1:0] sine_r;
  logic signed [34:0]       prod_r;
  logic signed [PW-1:0]     pos_r;
  logic signed [34:0]       acc_r;
  sample_t                  rd_data_r;
  logic                     rd_valid_r;

  logic [32+TIX_W:0]   tix_prod;
  logic signed [34:0]  round_sum;
  logic signed [19:0]  delay_q8;
  logic [AW-1:0]       p1, p2, rd_idx;
  logic [7:0]          frac;
  sample_t             rd_sample;
  logic signed [34:0]  mix_sum;

  assign tix_prod  = {{(TIX_W+1){1'b0}}, phase_r} * {32'd0, DEPTH_C};
  assign round_sum = prod_r + 35'sd16384;
  assign delay_q8  = 20'(round_sum >>> 15) + 20'sd76800;
  assign p1        = pos_r[AW+7:8];
  assign frac      = pos_r[7:0];
  assign p2        = (p1 == AW'(DELAY_LENGTH - 1)) ? '0 : p1 + 1'b1;
  assign rd_idx    = (state_r == ST_RD1) ? p1 : p2;
  assign rd_sample = rd_valid_r ? rd_data_r : '0;
  assign mix_sum   = 35'($signed({dry_r, 8'h00})) + acc_r;
  assign res_data  = mix_sum[32:9];

  assign cmd_pop  = (state_r == ST_IDLE) && !cmd_empty;
  assign res_push = (state_r == ST_MIX) && !res_full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (!cmd_empty) state_nxt = ST_IDX;
      ST_IDX:   state_nxt = ST_ROM;
      ST_ROM:   state_nxt = ST_SWING;
      ST_SWING: state_nxt = ST_POS;
      ST_POS:   state_nxt = ST_WRAP;
      ST_WRAP:  state_nxt = ST_WRAP2;
      ST_WRAP2: state_nxt = ST_RD1;
      ST_RD1:   state_nxt = ST_RD2;
      ST_RD2:   state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_MIX;
      ST_MIX:   if (!res_full) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Delay store: one write port, one registered read port.
  // Entries never written since reset read as zero via the fill tracking.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDX) begin
      store_mem[{ch_r, wi_r}] <= dry_r;
    end
    rd_data_r  <= store_mem[{ch_r, rd_idx}];
    rd_valid_r <= wrap_r || (rd_idx <= wi_r);
  end

  always_ff @(posedge clk) begin
    sine_r <= sine_rom[tix_r];
    case (state_r)
      ST_IDLE: begin
        {dry_r, ch_r, phase_r, wi_r, wrap_r} <= cmd_data;
      end
      ST_IDX: begin
        tix_r <= tix_prod[32 +: TIX_W];
      end
      ST_SWING: begin
        prod_r <= sine_r * $signed({1'b0, swing});
      end
      ST_POS: begin
        pos_r <= $signed({3'b000, wi_r, 8'h00}) - PW'(delay_q8);
      end
      ST_WRAP: begin
        if (pos_r < 0) begin
          pos_r <= pos_r + MOD_Q8;
        end else if (pos_r >= MOD_Q8) begin
          pos_r <= pos_r - MOD_Q8;
        end
      end
      ST_WRAP2: begin
        if (pos_r < 0) begin
          pos_r <= pos_r + MOD_Q8;
        end
      end
      ST_RD2: begin
        acc_r <= 35'(rd_sample) * 35'($signed({1'b0, 9'(9'd256 - {1'b0, frac})}));
      end
      ST_ACC: begin
        acc_r <= acc_r + 35'(rd_sample) * 35'($signed({2'b00, frac}));
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/chorus_modulated_delay_top.sv
// ---------------------------------------------------------------------------
// chorus_modulated_delay_top
// Two-channel chorus: per-channel sine-modulated delay line with linear
// interpolation, mixed half and half with the dry sample.
// ---------------------------------------------------------------------------
// A sample passes from the command queue to the result queue through the
// sequencer in the back end, which works step by step: one sine table
// read, four multiplies and two reads of the delay store, one after the
// other. The front end takes a new sample every cycle until its two-entry
// command queue fills, so with the back end idle a burst of up to three
// samples is absorbed; the back end takes the next sample only once the
// last one is pushed to the result queue. No clearing pass follows reset:
// fill tracking per channel makes store entries not yet written read as
// zero. Configuration registers are index 0, phase step, and index 1, swing
// (Q8 samples); other indexes are ignored.
`include "chorus_modulated_delay_top_defines.svh"

module chorus_modulated_delay_top #(
  parameter int DELAY_LENGTH     = 2048,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  chmd_pkg::cfg_idx_t    cfg_index,
  input  chmd_pkg::cfg_data_t   cfg_wdata,
  input  logic                  in_push,
  input  chmd_pkg::sample_t     in_sample_in,
  input  logic                  in_channel,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output chmd_pkg::sample_t     out_sample_out
);
  import chmd_pkg::*;

  localparam int AW    = $clog2(DELAY_LENGTH);
  localparam int CMD_W = SAMPLE_W + PHASE_W + AW + 2;

  logic [PHASE_W-1:0] phase_step_r;
  logic [SWING_W-1:0] swing_r;

  logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [CMD_W-1:0] cmd_wdata, cmd_rdata;
  logic             res_push, res_full;
  sample_t          res_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
      swing_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE_STEP: phase_step_r <= cfg_wdata[PHASE_W-1:0];
        CFG_SWING:      swing_r      <= cfg_wdata[SWING_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_full = cmd_full;

  chmd_front #(
    .DELAY_LENGTH(DELAY_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .sample_in (in_sample_in),
    .channel   (in_channel),
    .phase_step(phase_step_r),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_wdata)
  );

  chmd_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data(cmd_wdata),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .pop_data (cmd_rdata),
    .empty    (cmd_empty)
  );

  chmd_back #(
    .DELAY_LENGTH    (DELAY_LENGTH),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .swing    (swing_r),
    .cmd_empty(cmd_empty),
    .cmd_data (cmd_rdata),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data)
  );

  chmd_fifo #(
    .WIDTH(SAMPLE_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_data),
    .full     (res_full),
    .pop      (out_pop),
    .pop_data (out_sample_out),
    .empty    (out_empty)
  );

  `CHMD_ASSERT_NOW(a_res_push_room, clk, rst_n, res_push, !res_full, "result pushed into full queue")
  `CHMD_ASSERT_NOW(a_cmd_pop_avail, clk, rst_n, cmd_pop, !cmd_empty, "command popped from empty queue")
  `CHMD_ASSERT_NEXT(a_reset_empty, clk, !rst_n, out_empty && !in_full, "queues not clear after reset")

endmodule

### test/tb_chorus_modulated_delay_top.sv
// ---------------------------------------------------------------------------
// tb_chorus_modulated_delay_top
// Self-checking bench for the two-channel chorus delay. A clocked driver
// pushes samples from a pending queue, and a behavioral mixer tracks the
// delay stores, oscillator phases and write positions to work out each
// expected output. A clocked monitor pops results with random stalls and
// compares them in order. Directed samples cover the extremes, the phase
// wrap, the current-sample read, full swing and the unused register
// indexes. Random phases then sweep the phase step and swing.
// ---------------------------------------------------------------------------
module tb_chorus_modulated_delay_top;
  import chmd_pkg::*;

  localparam int DELAY_LEN  = 2048;
  localparam int SINE_DEPTH = 1024;
  localparam longint POS_MOD = longint'(DELAY_LEN) * 256;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 15;

  localparam cfg_idx_t CFG_SPARE_2 = 2'd2;
  localparam cfg_idx_t CFG_SPARE_3 = 2'd3;

  localparam sample_t SMP_MAX = 24'sh7fffff;
  localparam sample_t SMP_MIN = 24'sh800000;

  typedef struct {
    sample_t smp;
    logic    ch;
  } chorus_item_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  cfg_idx_t  cfg_index = '0;
  cfg_data_t cfg_wdata = '0;
  logic      in_push = 1'b0;
  sample_t   in_sample_in = '0;
  logic      in_channel = 1'b0;
  logic      in_full;
  logic      out_empty;
  logic      out_pop = 1'b0;
  sample_t   out_sample_out;

  chorus_item_t pend_q[$];
  sample_t      mix_q[$];
  int           fail_count = 0;
  bit           idle_on = 1'b1;
  int           push_wait = 0;
  int           pop_wait = 0;
  int           stall_cycles = 0;

  int           sine_lut [SINE_DEPTH];
  sample_t      delay_mem [2][DELAY_LEN];
  logic [31:0]  phase_acc [2];
  int           wr_pos [2];
  logic [31:0]  step_reg = '0;
  logic [17:0]  swing_reg = '0;

  chorus_modulated_delay_top #(
    .DELAY_LENGTH    (DELAY_LEN),
    .SINE_TABLE_DEPTH(SINE_DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_push       (in_push),
    .in_sample_in  (in_sample_in),
    .in_channel    (in_channel),
    .in_full       (in_full),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_sample_out(out_sample_out)
  );

  always #5 clk = ~clk;

  // sin over a quarter turn, argument and result Q30
  function automatic longint quarter_sine(longint x);
    longint term;
    longint acc;
    term = x;
    acc = x;
    for (int n = 1; n <= 7; n++) begin
      term = term * x / ONE_Q30;
      term = term * x / ONE_Q30;
      term = -term / longint'((2 * n) * (2 * n + 1));
      acc += term;
    end
    return (acc < 0) ? 64'sd0 : acc;
  endfunction

  function automatic void build_sine_lut();
    longint quad, rem, x, v;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      quad = longint'(4 * k) / SINE_DEPTH;
      rem = longint'(4 * k) % SINE_DEPTH;
      if (quad == 1 || quad == 3) begin
        rem = SINE_DEPTH - rem;
      end
      x = rem * HALF_PI_Q30 / SINE_DEPTH;
      v = (quarter_sine(x) + 64'sd16384) >>> 15;
      if (v > 32767) begin
        v = 32767;
      end
      if (quad >= 2) begin
        v = -v;
      end
      sine_lut[k] = int'(v);
    end
  endfunction

  // Write the dry sample, read the modulated tap, mix, advance the channel.
  function automatic sample_t mix_next(sample_t dry, logic ch);
    int     c, wi, tix, p1, p2, frac;
    longint delay_q8, pos, tap, mixed;
    c = int'(ch);
    wi = wr_pos[c];
    delay_mem[c][wi] = dry;
    tix = int'((64'(phase_acc[c]) * SINE_DEPTH) >> 32);
    delay_q8 = BASE_DELAY_Q8 +
               ((longint'(sine_lut[tix]) * longint'(swing_reg) + 64'sd16384) >>> 15);
    pos = (longint'(wi) * 256 - delay_q8) % POS_MOD;
    if (pos < 0) begin
      pos += POS_MOD;
    end
    p1 = int'(pos >>> 8) % DELAY_LEN;
    frac = int'(pos & 255);
    p2 = (p1 + 1) % DELAY_LEN;
    tap = longint'(delay_mem[c][p1]) * (256 - frac) +
          longint'(delay_mem[c][p2]) * frac;
    mixed = (longint'(dry) * 256 + tap) >>> 9;
    phase_acc[c] = phase_acc[c] + step_reg;
    wr_pos[c] = (wi + 1) % DELAY_LEN;
    return mixed[23:0];
  endfunction

  function automatic int draw_gap();
    return idle_on ? int'($urandom_range(0, 6)) : 0;
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return '0;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic queue_item(sample_t s, logic c);
    chorus_item_t it;
    it.smp = s;
    it.ch = c;
    pend_q.push_back(it);
  endtask

  task automatic queue_random(int count, int lean);
    logic c;
    for (int i = 0; i < count; i++) begin
      case (lean)
        1: c = ($urandom_range(0, 3) == 0);
        2: c = ($urandom_range(0, 3) != 0);
        default: c = $urandom_range(0, 1);
      endcase
      queue_item(random_sample(), c);
    end
  endtask

  task automatic cfg_write(cfg_idx_t idx, cfg_data_t data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_PHASE_STEP: step_reg = data;
      CFG_SWING: swing_reg = data[17:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (pend_q.size() != 0 || in_push || mix_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin : driver_proc
    int gap;
    chorus_item_t nxt;
    if (!rst_n) begin
      in_push <= 1'b0;
      in_sample_in <= '0;
      in_channel <= 1'b0;
      push_wait <= 0;
    end else if (in_push && !in_full) begin
      mix_q.push_back(mix_next(in_sample_in, in_channel));
      gap = draw_gap();
      if (gap == 0 && pend_q.size() != 0) begin
        nxt = pend_q.pop_front();
        in_sample_in <= nxt.smp;
        in_channel <= nxt.ch;
        in_push <= 1'b1;
      end else begin
        in_push <= 1'b0;
        push_wait <= gap;
      end
    end else if (!in_push) begin
      if (push_wait != 0) begin
        push_wait <= push_wait - 1;
      end else if (pend_q.size() != 0) begin
        nxt = pend_q.pop_front();
        in_sample_in <= nxt.smp;
        in_channel <= nxt.ch;
        in_push <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor_proc
    int gap;
    sample_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_wait <= 0;
    end else if (out_pop && !out_empty) begin
      if (mix_q.size() == 0) begin
        $error("sample_out: no transaction expected, actual %0d", out_sample_out);
        fail_count++;
      end else begin
        want = mix_q.pop_front();
        if (out_sample_out !== want) begin
          $error("sample_out: expected %0d, actual %0d", want, out_sample_out);
          fail_count++;
        end
      end
      gap = draw_gap();
      if (gap == 0) begin
        out_pop <= 1'b1;
      end else begin
        out_pop <= 1'b0;
        pop_wait <= gap;
      end
    end else if (!out_pop) begin
      if (pop_wait != 0) begin
        pop_wait <= pop_wait - 1;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    cfg_data_t steps [5];
    cfg_data_t swings [5];
    build_sine_lut();
    for (int c = 0; c < 2; c++) begin
      phase_acc[c] = '0;
      wr_pos[c] = 0;
      for (int i = 0; i < DELAY_LEN; i++) begin
        delay_mem[c][i] = '0;
      end
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration: fixed 300-sample tap, extremes of the sample
    queue_item(SMP_MAX, 1'b0);
    queue_item(SMP_MIN, 1'b0);
    queue_item(SMP_MIN, 1'b1);
    queue_item(SMP_MAX, 1'b1);
    queue_item('0, 1'b0);
    queue_item(-24'sd1, 1'b1);
    wait_drained();

    // quarter-turn step: sine walks 0, +1, 0, -1 and wraps; at -1 the tap
    // falls inside the newest sample
    cfg_write(CFG_PHASE_STEP, 32'h4000_0000);
    cfg_write(CFG_SWING, 32'd76800);
    for (int i = 0; i < 8; i++) begin
      queue_item((i % 3 == 0) ? SMP_MAX : (i % 3 == 1) ? SMP_MIN : 24'sh123456,
                 logic'(i >= 4));
    end
    wait_drained();

    // full swing with the phase stepping back from zero; spare indexes must be ignored
    cfg_write(CFG_PHASE_STEP, 32'hFFFF_FFFF);
    cfg_write(CFG_SWING, 32'hFFFF_FFFF);
    cfg_write(CFG_SPARE_2, $urandom);
    cfg_write(CFG_SPARE_3, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) begin
      queue_item((i % 2 == 0) ? SMP_MIN : SMP_MAX, logic'(i % 2));
    end
    wait_drained();

    steps[0] = $urandom;
    swings[0] = $urandom;
    steps[1] = '0;
    swings[1] = '0;
    steps[2] = $urandom_range(0, 1 << 24);
    swings[2] = 32'd76800;
    steps[3] = $urandom;
    swings[3] = 32'd262143;
    steps[4] = 32'hFFFF_FFFF;
    swings[4] = $urandom_range(0, 262143);
    for (int p = 0; p < 5; p++) begin
      idle_on = (p != 2);
      cfg_write(CFG_PHASE_STEP, steps[p]);
      cfg_write(CFG_SWING, swings[p]);
      if (p == 3) begin
        cfg_write(CFG_SPARE_2, $urandom);
      end
      queue_random(40, p % 3);
      wait_drained();
      queue_random(40, (p + 1) % 3);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
